@@ design/dmu_pkg.sv @@
package dmu_pkg;

  localparam int unsigned DEFAULT_DATA_WIDTH = 64;
  localparam int unsigned FIELD_WIDTH        = 64;

  typedef enum logic [1:0] {
    CMD_SDIV = 2'd0,
    CMD_SREM = 2'd1,
    CMD_UDIV = 2'd2,
    CMD_UREM = 2'd3
  } cmd_e;

  // Control that travels with an item down the divider pipeline
  typedef struct packed {
    logic valid;
    logic want_rem;
    logic neg_quo;
    logic neg_rem;
    logic div_zero;
  } ctrl_t;

endpackage

@@ design/dmu_div_stage.sv @@
module dmu_div_stage import dmu_pkg::*; #(
  parameter int unsigned DataWidth = DEFAULT_DATA_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_t                ctrl_i,
  input  logic [DataWidth-1:0] rem_i,
  input  logic [DataWidth-1:0] num_i,
  input  logic [DataWidth-1:0] den_i,
  output ctrl_t                ctrl_o,
  output logic [DataWidth-1:0] rem_o,
  output logic [DataWidth-1:0] num_o,
  output logic [DataWidth-1:0] den_o
);

  logic [DataWidth:0]   trial;
  logic [DataWidth+1:0] diff;
  logic                 take;
  logic [DataWidth-1:0] rem_d;
  logic [DataWidth-1:0] num_d;

  ctrl_t                ctrl_q;
  logic [DataWidth-1:0] rem_q;
  logic [DataWidth-1:0] num_q;
  logic [DataWidth-1:0] den_q;

  // Shift in the next dividend bit, keeping the carry as the top bit
  assign trial = {rem_i, num_i[DataWidth-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_i};
  assign take  = ~diff[DataWidth+1];
  assign rem_d = take ? diff[DataWidth-1:0] : trial[DataWidth-1:0];
  // Dividend bits leave at the top, quotient bits enter at the bottom
  assign num_d = {num_i[DataWidth-2:0], take};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_i;
  end

  assign ctrl_o = ctrl_q;
  assign rem_o  = rem_q;
  assign num_o  = num_q;
  assign den_o  = den_q;

endmodule

@@ design/int64_divide_modulo_unit.sv @@
// Pipelined divide / remainder unit: operand stage, one restoring step per
// stage for DATA_WIDTH stages, then a sign-fix and select stage.
// Throughput: one item per cycle; busy stays low and the receiver cannot stall.
// Reset (asynchronous, active low) clears all valid bits; items in flight are dropped.
module int64_divide_modulo_unit import dmu_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             command_i,
  input  logic [FIELD_WIDTH-1:0] dividend_i,
  input  logic [FIELD_WIDTH-1:0] divisor_i,
  output logic                   result_valid_o,
  output logic [FIELD_WIDTH-1:0] result_o,
  output logic                   divide_by_zero_o
);

  cmd_e                  cmd;
  logic [DATA_WIDTH-1:0] op_a;
  logic [DATA_WIDTH-1:0] op_b;
  logic                  is_signed;
  logic                  neg_a;
  logic                  neg_b;
  ctrl_t                 ctrl_d;
  logic [DATA_WIDTH-1:0] mag_a_d;
  logic [DATA_WIDTH-1:0] mag_b_d;

  ctrl_t                 ctrl_q;
  logic [DATA_WIDTH-1:0] mag_a_q;
  logic [DATA_WIDTH-1:0] mag_b_q;

  ctrl_t                 ctrl_s [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] rem_s  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] num_s  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] den_s  [0:DATA_WIDTH];

  ctrl_t                 ctrl_end;
  logic [DATA_WIDTH-1:0] quo;
  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] res;
  logic [FIELD_WIDTH-1:0] result_d;

  logic                   out_valid_q;
  logic [FIELD_WIDTH-1:0] result_q;
  logic                   div_zero_q;

  assign busy = 1'b0;

  // Operand stage: drop bits above the width and take magnitudes
  assign cmd       = cmd_e'(command_i);
  assign op_a      = dividend_i[DATA_WIDTH-1:0];
  assign op_b      = divisor_i[DATA_WIDTH-1:0];
  assign is_signed = (cmd == CMD_SDIV) || (cmd == CMD_SREM);
  assign neg_a     = is_signed & op_a[DATA_WIDTH-1];
  assign neg_b     = is_signed & op_b[DATA_WIDTH-1];
  assign mag_a_d   = neg_a ? (~op_a + 1'b1) : op_a;
  assign mag_b_d   = neg_b ? (~op_b + 1'b1) : op_b;

  always_comb begin
    ctrl_d          = '0;
    ctrl_d.valid    = start;
    ctrl_d.neg_quo  = neg_a ^ neg_b;
    ctrl_d.neg_rem  = neg_a;
    ctrl_d.div_zero = (op_b == '0);
    case (cmd)
      CMD_SREM, CMD_UREM: ctrl_d.want_rem = 1'b1;
      default:            ctrl_d.want_rem = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_a_q <= mag_a_d;
    mag_b_q <= mag_b_d;
  end

  assign ctrl_s[0] = ctrl_q;
  assign rem_s[0]  = '0;
  assign num_s[0]  = mag_a_q;
  assign den_s[0]  = mag_b_q;

  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
    dmu_div_stage #(
      .DataWidth(DATA_WIDTH)
    ) u_stage (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctrl_i(ctrl_s[k]),
      .rem_i (rem_s[k]),
      .num_i (num_s[k]),
      .den_i (den_s[k]),
      .ctrl_o(ctrl_s[k+1]),
      .rem_o (rem_s[k+1]),
      .num_o (num_s[k+1]),
      .den_o (den_s[k+1])
    );
  end

  // Output stage: fix signs, select quotient or remainder, force zero on a zero divisor
  assign ctrl_end = ctrl_s[DATA_WIDTH];
  assign quo      = ctrl_end.neg_quo ? (~num_s[DATA_WIDTH] + 1'b1) : num_s[DATA_WIDTH];
  assign rem      = ctrl_end.neg_rem ? (~rem_s[DATA_WIDTH] + 1'b1) : rem_s[DATA_WIDTH];

  always_comb begin
    if (ctrl_end.div_zero) begin
      res = '0;
    end else if (ctrl_end.want_rem) begin
      res = rem;
    end else begin
      res = quo;
    end
    result_d = FIELD_WIDTH'(res);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= ctrl_end.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q   <= result_d;
    div_zero_q <= ctrl_end.div_zero;
  end

  assign result_valid_o   = out_valid_q;
  assign result_o         = result_q;
  assign divide_by_zero_o = div_zero_q;

endmodule

@@ test/int64_divide_modulo_unit_checker.sv @@
`timescale 1ns / 1ps

module int64_divide_modulo_unit_checker import dmu_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   busy_i,
  input  logic [1:0]             command_i,
  input  logic [FIELD_WIDTH-1:0] dividend_i,
  input  logic [FIELD_WIDTH-1:0] divisor_i,
  input  logic                   result_valid_i,
  input  logic [FIELD_WIDTH-1:0] result_i,
  input  logic                   divide_by_zero_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  localparam logic [FIELD_WIDTH-1:0] WIDTH_MASK = {FIELD_WIDTH{1'b1}} >> (FIELD_WIDTH - DATA_WIDTH);

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] value;
    logic                   div_zero;
  } div_result_t;

  div_result_t expected_results_q[$];
  div_result_t oldest;
  int          fail_count = 0;

  // One restoring step per quotient bit; keep the carry of the partial remainder
  function automatic logic [FIELD_WIDTH-1:0] restoring_quotient(
    input logic [FIELD_WIDTH-1:0] num,
    input logic [FIELD_WIDTH-1:0] den
  );
    logic [FIELD_WIDTH-1:0] part_rem;
    logic [FIELD_WIDTH-1:0] quo;
    logic                   carry;
    part_rem = '0;
    quo      = '0;
    for (int k = DATA_WIDTH - 1; k >= 0; k--) begin
      carry    = part_rem[DATA_WIDTH-1];
      part_rem = ((part_rem << 1) | FIELD_WIDTH'(num[k])) & WIDTH_MASK;
      if (carry || part_rem >= den) begin
        part_rem = (part_rem - den) & WIDTH_MASK;
        quo[k]   = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic div_result_t divide_modulo(
    input cmd_e                   cmd,
    input logic [FIELD_WIDTH-1:0] dividend,
    input logic [FIELD_WIDTH-1:0] divisor
  );
    logic [FIELD_WIDTH-1:0] a;
    logic [FIELD_WIDTH-1:0] b;
    logic [FIELD_WIDTH-1:0] mag_a;
    logic [FIELD_WIDTH-1:0] mag_b;
    logic [FIELD_WIDTH-1:0] quo;
    logic                   neg_a;
    logic                   neg_b;
    div_result_t            res;
    a = dividend & WIDTH_MASK;
    b = divisor & WIDTH_MASK;
    res.value    = '0;
    res.div_zero = 1'b0;
    if (b == '0) begin
      res.div_zero = 1'b1;
      return res;
    end
    if (cmd == CMD_SDIV || cmd == CMD_SREM) begin
      neg_a = a[DATA_WIDTH-1];
      neg_b = b[DATA_WIDTH-1];
      mag_a = neg_a ? ((0 - a) & WIDTH_MASK) : a;
      mag_b = neg_b ? ((0 - b) & WIDTH_MASK) : b;
      quo   = restoring_quotient(mag_a, mag_b);
      if (neg_a != neg_b) quo = (0 - quo) & WIDTH_MASK;
    end else begin
      quo = restoring_quotient(a, b);
    end
    if (cmd == CMD_SDIV || cmd == CMD_UDIV) res.value = quo;
    else res.value = (a - quo * b) & WIDTH_MASK;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [FIELD_WIDTH-1:0] got,
                                 input logic [FIELD_WIDTH-1:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_i) begin
        if (expected_results_q.size() == 0) begin
          report_mismatch("unexpected result", result_i, '0);
        end else begin
          oldest = expected_results_q.pop_front();
          if (result_i !== oldest.value) report_mismatch("result", result_i, oldest.value);
          if (divide_by_zero_i !== oldest.div_zero)
            report_mismatch("divide_by_zero", FIELD_WIDTH'(divide_by_zero_i),
                            FIELD_WIDTH'(oldest.div_zero));
        end
      end
      if (start_i && !busy_i)
        expected_results_q.push_back(divide_modulo(cmd_e'(command_i), dividend_i, divisor_i));
    end
    fail_count_o <= fail_count;
    pending_o    <= expected_results_q.size();
  end

endmodule

@@ test/int64_divide_modulo_unit_tb.sv @@
`timescale 1ns / 1ps

module int64_divide_modulo_unit_tb;
  import dmu_pkg::*;

  localparam int LATENCY      = DEFAULT_DATA_WIDTH + 2;
  localparam int RANDOM_ITEMS = 2000;
  localparam int DRAIN_LIMIT  = 20 * LATENCY;

  localparam logic [FIELD_WIDTH-1:0] ALL_ONES = {FIELD_WIDTH{1'b1}};
  localparam logic [FIELD_WIDTH-1:0] MOST_NEG = {1'b1, {(FIELD_WIDTH-1){1'b0}}};
  localparam logic [FIELD_WIDTH-1:0] MOST_POS = {1'b0, {(FIELD_WIDTH-1){1'b1}}};

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic [1:0]             command_i;
  logic [FIELD_WIDTH-1:0] dividend_i;
  logic [FIELD_WIDTH-1:0] divisor_i;
  logic                   result_valid_o;
  logic [FIELD_WIDTH-1:0] result_o;
  logic                   divide_by_zero_o;
  int                     fail_count;
  int                     pending;
  bit                     gap_free;

  always #1 clk_i = ~clk_i;

  int64_divide_modulo_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .dividend_i      (dividend_i),
    .divisor_i       (divisor_i),
    .result_valid_o  (result_valid_o),
    .result_o        (result_o),
    .divide_by_zero_o(divide_by_zero_o)
  );

  int64_divide_modulo_unit_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .command_i       (command_i),
    .dividend_i      (dividend_i),
    .divisor_i       (divisor_i),
    .result_valid_i  (result_valid_o),
    .result_i        (result_o),
    .divide_by_zero_i(divide_by_zero_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // Present one item after a random gap (none in gap-free stretches) and hold it until it is taken
  task automatic send_division(input cmd_e cmd, input logic [FIELD_WIDTH-1:0] a,
                               input logic [FIELD_WIDTH-1:0] b);
    int gap;
    gap = gap_free ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    command_i  <= cmd;
    dividend_i <= a;
    divisor_i  <= b;
    do @(posedge clk_i); while (busy);
  endtask

  function automatic logic [FIELD_WIDTH-1:0] random_operand();
    logic [FIELD_WIDTH-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 6))
      0:       v = FIELD_WIDTH'($urandom_range(0, 255));
      1:       v = 0 - FIELD_WIDTH'($urandom_range(1, 255));
      2:       v = v >> $urandom_range(1, FIELD_WIDTH - 1);
      3:       v = ~(v >> $urandom_range(1, FIELD_WIDTH - 1));
      4: begin
        case ($urandom_range(0, 4))
          0:       v = '0;
          1:       v = FIELD_WIDTH'(1);
          2:       v = ALL_ONES;
          3:       v = MOST_NEG;
          default: v = MOST_POS;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    logic [FIELD_WIDTH-1:0] b;
    rst_ni     <= 1'b0;
    start      <= 1'b0;
    command_i  <= CMD_SDIV;
    dividend_i <= '0;
    divisor_i  <= '0;
    gap_free   = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero divisor under every command
    send_division(CMD_SDIV, ALL_ONES, '0);
    send_division(CMD_SREM, MOST_NEG, '0);
    send_division(CMD_UDIV, '0, '0);
    send_division(CMD_UREM, MOST_POS, '0);
    // Most negative by minus one
    send_division(CMD_SDIV, MOST_NEG, ALL_ONES);
    send_division(CMD_SREM, MOST_NEG, ALL_ONES);
    // Sign combinations: truncation toward zero, remainder follows dividend
    send_division(CMD_SDIV, 0 - FIELD_WIDTH'(7), FIELD_WIDTH'(2));
    send_division(CMD_SREM, 0 - FIELD_WIDTH'(7), FIELD_WIDTH'(2));
    send_division(CMD_SDIV, FIELD_WIDTH'(7), 0 - FIELD_WIDTH'(2));
    send_division(CMD_SREM, FIELD_WIDTH'(7), 0 - FIELD_WIDTH'(2));
    send_division(CMD_SDIV, 0 - FIELD_WIDTH'(7), 0 - FIELD_WIDTH'(2));
    send_division(CMD_SREM, 0 - FIELD_WIDTH'(7), 0 - FIELD_WIDTH'(2));
    send_division(CMD_SDIV, MOST_POS, FIELD_WIDTH'(1));
    send_division(CMD_SREM, MOST_NEG, FIELD_WIDTH'(3));
    // Unsigned extremes and divisors with the top bit set
    send_division(CMD_UDIV, ALL_ONES, FIELD_WIDTH'(1));
    send_division(CMD_UREM, ALL_ONES, ALL_ONES);
    send_division(CMD_UDIV, ALL_ONES, MOST_NEG);
    send_division(CMD_UREM, ALL_ONES, MOST_NEG);
    send_division(CMD_UDIV, MOST_POS, ALL_ONES);
    send_division(CMD_UREM, MOST_POS, MOST_NEG + 1);
    send_division(CMD_UDIV, '0, ALL_ONES);
    send_division(CMD_SDIV, '0, MOST_NEG);
    send_division(CMD_SREM, ALL_ONES, MOST_NEG);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Switch between back-to-back stretches and gapped ones
      if (n % 50 == 0) gap_free = ($urandom_range(0, 3) == 0);
      b = ($urandom_range(0, 31) == 0) ? '0 : random_operand();
      send_division(cmd_e'($urandom_range(0, 3)), random_operand(), b);
    end
    start <= 1'b0;

    for (int w = 0; w < DRAIN_LIMIT && pending != 0; w++) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("[int64_divide_modulo_unit] OK");
    end else begin
      $display("[int64_divide_modulo_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("[int64_divide_modulo_unit] ERROR");
    $finish;
  end

endmodule
